// ----- design/lfg_pkg.sv -----
package lfg_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int WIDTH_W    = 7;
  localparam int LANE_CELLS = 8;
  localparam int NUM_LANES  = MAX_WIDTH / LANE_CELLS;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_WIDTH_IN_USE = 1'b0;

  typedef logic [MAX_WIDTH-1:0] lfg_row_t;

  typedef struct packed {
    lfg_row_t cells;
    logic     last;
  } lfg_beat_t;

  // second is only ever set together with first
  typedef struct packed {
    logic first;
    logic second;
  } lfg_push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] level;
    logic              pop;
  } lfg_qstat_t;

  function automatic lfg_row_t cell_mask(input logic [WIDTH_W-1:0] w);
    lfg_row_t m;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      m[i] = (32'(w) > i);
    end
    return m;
  endfunction

endpackage

// ----- design/lfg_lane.sv -----
module lfg_lane (
  input  logic [lfg_pkg::LANE_CELLS+1:0] up,
  input  logic [lfg_pkg::LANE_CELLS+1:0] mid,
  input  logic [lfg_pkg::LANE_CELLS+1:0] down,
  output logic [lfg_pkg::LANE_CELLS-1:0] next_cells
);

  // bit 0 and the top bit of each slice are the neighbours from the adjacent lanes
  always_comb begin
    logic [3:0] n;
    for (int j = 0; j < lfg_pkg::LANE_CELLS; j++) begin
      n = 4'(up[j]) + 4'(up[j+1]) + 4'(up[j+2])
        + 4'(mid[j]) + 4'(mid[j+2])
        + 4'(down[j]) + 4'(down[j+1]) + 4'(down[j+2]);
      next_cells[j] = (n == 4'd3) || ((n == 4'd2) && mid[j+1]);
    end
  end

endmodule

// ----- design/lfg_evolve.sv -----
module lfg_evolve (
  input  lfg_pkg::lfg_row_t up,
  input  lfg_pkg::lfg_row_t mid,
  input  lfg_pkg::lfg_row_t down,
  input  lfg_pkg::lfg_row_t mask,
  output lfg_pkg::lfg_row_t next_row
);

  // dead border on both sides, no wrap
  logic [lfg_pkg::MAX_WIDTH+1:0] up_pad, mid_pad, down_pad;
  lfg_pkg::lfg_row_t             merged;

  assign up_pad   = {1'b0, up,   1'b0};
  assign mid_pad  = {1'b0, mid,  1'b0};
  assign down_pad = {1'b0, down, 1'b0};

  for (genvar i = 0; i < lfg_pkg::NUM_LANES; i++) begin : g_lane
    lfg_lane u_lane (
      .up         (up_pad  [lfg_pkg::LANE_CELLS*i +: lfg_pkg::LANE_CELLS+2]),
      .mid        (mid_pad [lfg_pkg::LANE_CELLS*i +: lfg_pkg::LANE_CELLS+2]),
      .down       (down_pad[lfg_pkg::LANE_CELLS*i +: lfg_pkg::LANE_CELLS+2]),
      .next_cells (merged  [lfg_pkg::LANE_CELLS*i +: lfg_pkg::LANE_CELLS])
    );
  end

  assign next_row = merged & mask;

endmodule

// ----- design/lfg_out_queue.sv -----
module lfg_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  lfg_pkg::lfg_push_t  push,
  input  lfg_pkg::lfg_beat_t  beat0,
  input  lfg_pkg::lfg_beat_t  beat1,
  input  logic                out_stall,
  output logic                out_valid,
  output lfg_pkg::lfg_beat_t  out_beat,
  output lfg_pkg::lfg_qstat_t stat
);

  lfg_pkg::lfg_beat_t              mem_r [lfg_pkg::QDEPTH];
  logic [lfg_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [lfg_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [lfg_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic [lfg_pkg::QPTR_W-1:0]      wr_ptr_p1;
  logic                            pop;

  assign out_valid = (count_r != '0);
  assign out_beat  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + lfg_pkg::QPTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + lfg_pkg::QPTR_W'(push.first) + lfg_pkg::QPTR_W'(push.second);
    rd_ptr_nxt = rd_ptr_r + lfg_pkg::QPTR_W'(pop);
    count_nxt  = count_r + lfg_pkg::QCNT_W'(push.first) + lfg_pkg::QCNT_W'(push.second)
               - lfg_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem_r[wr_ptr_r] <= beat0;
    end
    if (push.second) begin
      mem_r[wr_ptr_p1] <= beat1;
    end
  end

  assign stat.level = count_r;
  assign stat.pop   = pop;

endmodule

// ----- design/life_generation_step_unit.sv -----
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall   | in_row_cells, in_last_row
// out     | output    | out_valid/out_stall | out_next_row_cells, out_last_out
// cfg     | APB slave | psel/penable/pready | paddr, pwdata, prdata
//
// One row accepted per cycle while in_stall is low; results leave a four-entry
// queue one per cycle unless out_stall; closing a multi-row grid pushes two.
// A result can leave the cycle after the row below it (or a last row) is taken.
// in_stall rises while fewer than two queue entries are free.
// Synchronous active-low reset clears the row state, queue and width (to 64).
module life_generation_step_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [63:0]                        in_row_cells,
  input  logic                               in_last_row,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [63:0]                        out_next_row_cells,
  output logic                               out_last_out,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lfg_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [lfg_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lfg_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  logic [lfg_pkg::WIDTH_W-1:0] width_r;
  lfg_pkg::lfg_row_t           row_above_r, row_held_r;
  logic                        have_row_r;
  lfg_pkg::lfg_row_t           row_above_nxt, row_held_nxt;
  logic                        have_row_nxt;

  lfg_pkg::lfg_row_t   mask, cur, held_or_zero, res_held, res_cur;
  lfg_pkg::lfg_push_t  push;
  lfg_pkg::lfg_beat_t  beat0, beat1, out_beat;
  lfg_pkg::lfg_qstat_t qstat;
  logic                accept, cfg_wr;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == lfg_pkg::REG_WIDTH_IN_USE) ?
                  lfg_pkg::APB_DATA_W'(width_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= lfg_pkg::WIDTH_W'(lfg_pkg::MAX_WIDTH);
    end else if (cfg_wr && (paddr[2] == lfg_pkg::REG_WIDTH_IN_USE)) begin
      width_r <= pwdata[lfg_pkg::WIDTH_W-1:0];
    end
  end

  // widths above the row saturate inside cell_mask
  assign mask         = lfg_pkg::cell_mask(width_r);
  assign cur          = in_row_cells & mask;
  assign held_or_zero = have_row_r ? row_held_r : '0;
  assign accept       = in_valid && !in_stall;
  assign in_stall     = (qstat.level > lfg_pkg::QCNT_W'(lfg_pkg::QDEPTH - 2));

  lfg_evolve u_evolve_held (
    .up       (row_above_r),
    .mid      (row_held_r),
    .down     (cur),
    .mask     (mask),
    .next_row (res_held)
  );

  lfg_evolve u_evolve_cur (
    .up       (held_or_zero),
    .mid      (cur),
    .down     ('0),
    .mask     (mask),
    .next_row (res_cur)
  );

  always_comb begin
    push   = '0;
    beat0  = '{cells: res_held, last: 1'b0};
    beat1  = '{cells: res_cur,  last: 1'b1};
    row_above_nxt = row_above_r;
    row_held_nxt  = row_held_r;
    have_row_nxt  = have_row_r;
    if (accept) begin
      if (have_row_r) begin
        push.first  = 1'b1;
        push.second = in_last_row;
      end else if (in_last_row) begin
        // single-row grid: its own result goes first
        push.first = 1'b1;
        beat0      = beat1;
      end
      if (in_last_row) begin
        row_above_nxt = '0;
        row_held_nxt  = '0;
        have_row_nxt  = 1'b0;
      end else begin
        row_above_nxt = held_or_zero;
        row_held_nxt  = cur;
        have_row_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_above_r <= '0;
      row_held_r  <= '0;
      have_row_r  <= 1'b0;
    end else begin
      row_above_r <= row_above_nxt;
      row_held_r  <= row_held_nxt;
      have_row_r  <= have_row_nxt;
    end
  end

  lfg_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .beat0     (beat0),
    .beat1     (beat1),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_beat  (out_beat),
    .stat      (qstat)
  );

  assign out_next_row_cells = out_beat.cells;
  assign out_last_out       = out_beat.last;

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_row |=> !have_row_r)
    else $error("row state not cleared after last row");

  a_no_row_dead_above: assert property (@(posedge clk) disable iff (!rst_n)
    !have_row_r |-> (row_above_r == '0) && (row_held_r == '0))
    else $error("stale row state with no row held");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.level <= lfg_pkg::QCNT_W'(lfg_pkg::QDEPTH))
    else $error("output queue overrun");

  a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
    accept && have_row_r && in_last_row && !qstat.pop |=>
      qstat.level == $past(qstat.level) + lfg_pkg::QCNT_W'(2))
    else $error("closing row did not queue two beats");
`endif

endmodule
